[hw/rtl/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define CPMD_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also covers the reset cycles.
`define CPMD_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/cpmd_pkg.sv]
`default_nettype none
package cpmd_pkg;

    // Rotation steps of the CORDIC unit, bounded by the arctangent table.
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_ITERS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

    // Divider geometry.
    localparam int DIV_NUM_W = 80;
    localparam int DIV_DEN_W = 64;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    // Physical and angle constants.
    localparam logic [19:0] G_Q16 = 20'd643564;
    localparam logic [29:0] K_Q30 = 30'd652032874;
    localparam logic signed [34:0] PI_Z = 35'sd3373259426;
    localparam logic signed [34:0] HALF_PI_Z = 35'sd1686629713;
    localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
    localparam logic [30:0] GRIP_MAX = 31'h7FFF_FFFF;
    localparam logic signed [17:0] HEAD_ONE = 18'sd65536;

    // Floor of 2^51 over two pi in Q2.30, used to estimate whole turns.
    localparam logic [18:0] TWO_PI_RECIP = 19'd333772;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_FRICTION = 3'd0,
        CFG_GAS      = 3'd1,
        CFG_BRAKE    = 3'd2,
        CFG_FLOOR    = 3'd3,
        CFG_VREF     = 3'd4
    } t_cfg_idx;

    // Sequencer states of one tick.
    typedef enum logic [5:0] {
        S_IDLE, S_SQX, S_SQY, S_SQSUM, S_VREF2, S_GMU, S_RATIO, S_GRIPA, S_GRIPB,
        S_GRIPC, S_ACC, S_STEP, S_STEP2, S_VELX, S_VELY, S_VELY2, S_DOTX, S_DOTY,
        S_DOTS, S_LAT0, S_LAT1, S_LAT2, S_LATW, S_RDIV, S_TH0, S_TH1, S_THDIV,
        S_MOD0, S_MOD1, S_MOD2, S_CKHX, S_CKHY, S_CKH, S_CHW, S_CKVY, S_CKV, S_CVW,
        S_POSX, S_POSY, S_POSS, S_OUT
    } t_state;

    // Arctangent of 2^-i in Q2.30.
    function automatic logic [29:0] cpmd_atan(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0: v = 30'd843314857;
            5'd1: v = 30'd497837829;
            5'd2: v = 30'd263043837;
            5'd3: v = 30'd133525159;
            5'd4: v = 30'd67021687;
            5'd5: v = 30'd33543516;
            5'd6: v = 30'd16775851;
            5'd7: v = 30'd8388437;
            5'd8: v = 30'd4194283;
            5'd9: v = 30'd2097149;
            5'd10: v = 30'd1048576;
            5'd11: v = 30'd524288;
            5'd12: v = 30'd262144;
            5'd13: v = 30'd131072;
            5'd14: v = 30'd65536;
            5'd15: v = 30'd32768;
            5'd16: v = 30'd16384;
            5'd17: v = 30'd8192;
            5'd18: v = 30'd4096;
            5'd19: v = 30'd2048;
            5'd20: v = 30'd1024;
            5'd21: v = 30'd512;
            5'd22: v = 30'd256;
            5'd23: v = 30'd128;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] cpmd_sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -68'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Clamp a heading component to the unit range.
    function automatic logic signed [17:0] cpmd_clamp_head(input logic signed [33:0] v);
        logic signed [17:0] r;
        if (v > 34'sd65536) begin
            r = HEAD_ONE;
        end else if (v < -34'sd65536) begin
            r = -HEAD_ONE;
        end else begin
            r = v[17:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/cpmd_if.sv]
`default_nettype none
// Input channel: one beat per simulation tick.
interface cpmd_in_if;
    logic        valid;
    logic        ready;
    logic        gas_pedal;
    logic        brake_pedal;
    logic        steer_left;
    logic        steer_right;
    logic [15:0] dt_step;
    modport source(output valid, gas_pedal, brake_pedal, steer_left, steer_right, dt_step,
                   input ready);
    modport sink(input valid, gas_pedal, brake_pedal, steer_left, steer_right, dt_step,
                 output ready);
endinterface

// Result channel: the car state after each tick.
interface cpmd_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [17:0] head_x;
    logic signed [17:0] head_y;
    modport source(output valid, pos_x, pos_y, vel_x, vel_y, head_x, head_y, input ready);
    modport sink(input valid, pos_x, pos_y, vel_x, vel_y, head_x, head_y, output ready);
endinterface

// Configuration write channel.
interface cpmd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/cpmd_mul.sv]
`default_nettype none
// Shared signed multiplier with a registered product.
module cpmd_mul (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [65:0] o_p
);
    logic signed [65:0] r_p;

    // Product is registered and appears in the cycle after the operands.
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule
`default_nettype wire

[hw/rtl/cpmd_div.sv]
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module cpmd_div import cpmd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic                 o_busy,
    output logic [DIV_NUM_W-1:0] o_quo
);
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic [DIV_DEN_W:0]   w_trial;
    logic [DIV_DEN_W:0]   w_diff;
    logic                 w_ge;

    // Trial subtraction of the divisor from the shifted remainder.
    assign w_trial = {r_rem, r_num[DIV_NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    // Busy flag and step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Quotient bits shift in where the dividend bits shift out.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DIV_DEN_W-1:0] : w_trial[DIV_DEN_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_num;
endmodule
`default_nettype wire

[hw/rtl/cpmd_sqrt.sv]
`default_nettype none
// Floor square root of a 64-bit value, two radicand bits per cycle.
module cpmd_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_val,
    output logic        o_busy,
    output logic [31:0] o_root
);
    logic [63:0] r_v;
    logic [63:0] r_r;
    logic [63:0] r_bit;
    logic        r_busy;
    logic [63:0] w_t;
    logic        w_ge;

    assign w_t  = r_r + r_bit;
    assign w_ge = r_v >= w_t;

    // Busy until the last bit pair has been resolved.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_bit[0]) begin
            r_busy <= 1'b0;
        end
    end

    // One digit of the classic bitwise root per cycle.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_val;
            r_r   <= '0;
            r_bit <= 64'h4000_0000_0000_0000;
        end else if (r_busy) begin
            if (w_ge) begin
                r_v <= r_v - w_t;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_r[31:0];
endmodule
`default_nettype wire

[hw/rtl/cpmd_cordic.sv]
`default_nettype none
// Iterative CORDIC rotation, one micro-rotation per cycle.
module cpmd_cordic import cpmd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_x,
    input  logic signed [63:0] i_y,
    input  logic signed [34:0] i_z,
    output logic               o_busy,
    output logic signed [33:0] o_x,
    output logic signed [33:0] o_y
);
    logic signed [63:0] r_x;
    logic signed [63:0] r_y;
    logic signed [34:0] r_z;
    logic [4:0]         r_i;
    logic               r_busy;
    logic signed [63:0] w_dx;
    logic signed [63:0] w_dy;
    logic signed [34:0] w_atan;
    logic signed [63:0] w_rx;
    logic signed [63:0] w_ry;

    assign w_dx   = r_y >>> r_i;
    assign w_dy   = r_x >>> r_i;
    assign w_atan = $signed(35'(cpmd_atan(r_i)));

    // Iteration counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_i    <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_i    <= '0;
        end else if (r_busy) begin
            r_i <= r_i + 1'b1;
            if (r_i == 5'(CORDIC_ITERS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Half-turn pre-rotation on load, then the micro-rotations.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            if (i_z > HALF_PI_Z) begin
                r_x <= -i_x;
                r_y <= -i_y;
                r_z <= i_z - PI_Z;
            end else if (i_z < -HALF_PI_Z) begin
                r_x <= -i_x;
                r_y <= -i_y;
                r_z <= i_z + PI_Z;
            end else begin
                r_x <= i_x;
                r_y <= i_y;
                r_z <= i_z;
            end
        end else if (r_busy) begin
            if (r_z >= 0) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_atan;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_atan;
            end
        end
    end

    // Round to nearest when dropping the Q0.30 gain fraction.
    assign w_rx   = r_x + 64'sd536870912;
    assign w_ry   = r_y + 64'sd536870912;
    assign o_x    = w_rx[63:30];
    assign o_y    = w_ry[63:30];
    assign o_busy = r_busy;
endmodule
`default_nettype wire

[hw/rtl/car_point_mass_dynamics_step.sv]
`default_nettype none
// Point-mass car, one simulation tick per input beat.
// i_in carries the pedals, the steering keys and the time step dt. o_out carries
// the position, velocity and heading after the tick. i_cfg writes the five tuning
// registers (friction, gas, brake, turn radius floor, downforce speed); it is
// always ready and should only be used while no tick is in flight.
// A steering tick runs more sequencer states than a tick without steering. The
// sequencer works around a single 33x33 multiplier and drives the shared 80-step
// restoring divider (grip ratio, radius and angle), the 32-step square root and
// two 16-step CORDIC passes; the first root runs alongside the grip ratio
// division, the other units one after another. The block takes one tick at a
// time: i_in.ready is high only while the sequencer is idle.
// Results sit in an output register; the next tick is accepted while a result
// still waits, and the sequencer holds a result until that register frees up.
// Reset is synchronous: it restores the default tuning values, puts the car at
// the origin at rest facing +x and drops any pending result.
module car_point_mass_dynamics_step import cpmd_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    cpmd_in_if.sink        i_in,
    cpmd_out_if.source     o_out,
    cpmd_cfg_if.sink       i_cfg
);
    t_state r_state;
    t_state n_state;

    // Tuning registers.
    logic [17:0] r_mu;
    logic [22:0] r_gas_accel;
    logic [22:0] r_brake_decel;
    logic [22:0] r_floor;
    logic [23:0] r_vref;

    // Car state.
    logic signed [31:0] r_px, r_py, r_vx, r_vy;
    logic signed [17:0] r_hx, r_hy;

    // Tick inputs and intermediates.
    logic               r_gas, r_brake, r_left, r_right;
    logic [15:0]        r_dt;
    logic [63:0]        r_s;
    logic [31:0]        r_speed;
    logic [47:0]        r_vref2;
    logic [20:0]        r_gmu;
    logic [46:0]        r_ratio;
    logic [30:0]        r_grip;
    logic [22:0]        r_acc;
    logic signed [32:0] r_step;
    logic [63:0]        r_t;
    logic signed [65:0] r_dot;
    logic [63:0]        r_rad;
    logic signed [34:0] r_z;
    logic signed [63:0] r_cx;

    // Result register.
    logic               r_out_valid;
    logic signed [31:0] r_o_px, r_o_py, r_o_vx, r_o_vy;
    logic signed [17:0] r_o_hx, r_o_hy;

    // Shared unit connections.
    logic signed [32:0]   w_ma, w_mb;
    logic signed [65:0]   w_prod;
    logic                 w_div_start, w_div_busy;
    logic [DIV_NUM_W-1:0] w_div_num, w_quo;
    logic [DIV_DEN_W-1:0] w_div_den;
    logic                 w_sq_start, w_sq_busy;
    logic [63:0]          w_sq_val;
    logic [31:0]          w_root;
    logic                 w_cd_start, w_cd_busy;
    logic signed [63:0]   w_cd_x, w_cd_y;
    logic signed [33:0]   w_cd_ox, w_cd_oy;

    // Helpers.
    logic               w_accept;
    logic               w_pedal;
    logic               w_out_load;
    logic [23:0]        w_vref;
    logic [22:0]        w_floor;
    logic [22:0]        w_sel;
    logic [63:0]        w_grip_sum;
    logic [22:0]        w_step_mag;
    logic signed [32:0] w_step_pos;
    logic [63:0]        w_rq;
    logic signed [34:0] w_zr;
    logic signed [34:0] w_zw;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_pedal    = r_gas != r_brake;
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || o_out.ready);
    assign w_vref     = (r_vref == '0) ? 24'd1 : r_vref;
    assign w_floor    = (r_floor == '0) ? 23'd1 : r_floor;
    assign w_sel      = r_gas ? r_gas_accel : r_brake_decel;
    assign w_grip_sum = r_t + (w_prod[63:0] >> 16);
    assign w_step_mag = w_prod[38:16];
    assign w_step_pos = $signed(33'(w_step_mag));
    assign w_rq       = w_quo[63:0];
    // The turn estimate is at most one short, so one fix-up finishes the wrap.
    assign w_zr       = $signed(35'((r_t >= 64'(TWO_PI_Q30)) ? r_t - 64'(TWO_PI_Q30) : r_t));
    assign w_zw       = (w_zr > PI_Z) ? w_zr - $signed(35'(TWO_PI_Q30)) : w_zr;

    assign i_in.ready  = r_state == S_IDLE;
    assign i_cfg.ready = 1'b1;

    // Shared units.
    cpmd_mul u_mul (
        .i_clk(i_clk), .i_a(w_ma), .i_b(w_mb), .o_p(w_prod)
    );

    cpmd_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start), .i_num(w_div_num),
        .i_den(w_div_den), .o_busy(w_div_busy), .o_quo(w_quo)
    );

    cpmd_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_sq_start), .i_val(w_sq_val),
        .o_busy(w_sq_busy), .o_root(w_root)
    );

    cpmd_cordic u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_cd_start), .i_x(w_cd_x),
        .i_y(w_cd_y), .i_z(r_z), .o_busy(w_cd_busy), .o_x(w_cd_ox), .o_y(w_cd_oy)
    );

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer: next state, multiplier operands and unit launches.
    always_comb begin
        n_state     = r_state;
        w_ma        = '0;
        w_mb        = '0;
        w_div_start = 1'b0;
        w_div_num   = '0;
        w_div_den   = '0;
        w_sq_start  = 1'b0;
        w_sq_val    = r_s;
        w_cd_start  = 1'b0;
        w_cd_x      = r_cx;
        w_cd_y      = w_prod[63:0];
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SQX;
                end
            end
            S_SQX: begin
                w_ma = 33'(r_vx);
                w_mb = 33'(r_vx);
                n_state = S_SQY;
            end
            S_SQY: begin
                w_ma = 33'(r_vy);
                w_mb = 33'(r_vy);
                n_state = S_SQSUM;
            end
            S_SQSUM: begin
                w_ma = $signed(33'(w_vref));
                w_mb = $signed(33'(w_vref));
                n_state = S_VREF2;
            end
            S_VREF2: begin
                w_ma = $signed(33'(r_mu));
                w_mb = $signed(33'(G_Q16));
                w_sq_start = 1'b1;
                n_state = S_GMU;
            end
            S_GMU: begin
                w_div_start = 1'b1;
                w_div_num   = {r_s, 16'd0};
                w_div_den   = 64'(r_vref2);
                n_state = S_RATIO;
            end
            S_RATIO: begin
                if (!w_div_busy && !w_sq_busy) begin
                    n_state = S_GRIPA;
                end
            end
            S_GRIPA: begin
                w_ma = $signed(33'(r_gmu));
                w_mb = $signed(33'(r_ratio[46:16]));
                n_state = S_GRIPB;
            end
            S_GRIPB: begin
                w_ma = $signed(33'(r_gmu));
                w_mb = $signed(33'(r_ratio[15:0]));
                n_state = S_GRIPC;
            end
            S_GRIPC: n_state = S_ACC;
            S_ACC: n_state = S_STEP;
            S_STEP: begin
                w_ma = $signed(33'(r_acc));
                w_mb = $signed(33'(r_dt));
                n_state = S_STEP2;
            end
            S_STEP2: n_state = w_pedal ? S_VELX : S_LAT0;
            S_VELX: begin
                w_ma = 33'(r_hx);
                w_mb = r_step;
                n_state = S_VELY;
            end
            S_VELY: begin
                w_ma = 33'(r_hy);
                w_mb = r_step;
                n_state = S_VELY2;
            end
            S_VELY2: n_state = r_brake ? S_DOTX : S_LAT0;
            S_DOTX: begin
                w_ma = 33'(r_vx);
                w_mb = 33'(r_hx);
                n_state = S_DOTY;
            end
            S_DOTY: begin
                w_ma = 33'(r_vy);
                w_mb = 33'(r_hy);
                n_state = S_DOTS;
            end
            S_DOTS: n_state = S_LAT0;
            S_LAT0: begin
                w_ma = $signed(33'(r_grip));
                w_mb = $signed(33'(r_grip));
                n_state = (r_left != r_right) ? S_LAT1 : S_POSX;
            end
            S_LAT1: begin
                w_ma = $signed(33'(r_acc));
                w_mb = $signed(33'(r_acc));
                n_state = S_LAT2;
            end
            S_LAT2: begin
                w_sq_start = 1'b1;
                w_sq_val   = r_t - w_prod[63:0];
                n_state = S_LATW;
            end
            S_LATW: begin
                if (!w_sq_busy) begin
                    if (r_speed == '0 || w_root == '0) begin
                        n_state = S_POSX;
                    end else begin
                        w_div_start = 1'b1;
                        w_div_num   = 80'(r_s);
                        w_div_den   = 64'(w_root);
                        n_state = S_RDIV;
                    end
                end
            end
            S_RDIV: begin
                if (!w_div_busy) begin
                    n_state = S_TH0;
                end
            end
            S_TH0: begin
                w_ma = $signed(33'(r_speed));
                w_mb = $signed(33'(r_dt));
                n_state = S_TH1;
            end
            S_TH1: begin
                w_div_start = 1'b1;
                w_div_num   = {18'd0, w_prod[47:0], 14'd0};
                w_div_den   = r_rad;
                n_state = S_THDIV;
            end
            // The angle stays below 2^47, so its top bits times the reciprocal
            // of two pi give the whole turns to within one.
            S_THDIV: begin
                if (!w_div_busy) begin
                    w_ma = $signed(33'(w_rq[46:15]));
                    w_mb = $signed(33'(TWO_PI_RECIP));
                    n_state = S_MOD0;
                end
            end
            S_MOD0: begin
                w_ma = $signed(33'(w_prod[49:36]));
                w_mb = 33'(PI_Z);
                n_state = S_MOD1;
            end
            S_MOD1: n_state = S_MOD2;
            S_MOD2: n_state = S_CKHX;
            S_CKHX: begin
                w_ma = 33'(r_hx);
                w_mb = $signed(33'(K_Q30));
                n_state = S_CKHY;
            end
            S_CKHY: begin
                w_ma = 33'(r_hy);
                w_mb = $signed(33'(K_Q30));
                n_state = S_CKH;
            end
            S_CKH: begin
                w_cd_start = 1'b1;
                n_state = S_CHW;
            end
            S_CHW: begin
                w_ma = 33'(r_vx);
                w_mb = $signed(33'(K_Q30));
                if (!w_cd_busy) begin
                    n_state = S_CKVY;
                end
            end
            S_CKVY: begin
                w_ma = 33'(r_vy);
                w_mb = $signed(33'(K_Q30));
                n_state = S_CKV;
            end
            S_CKV: begin
                w_cd_start = 1'b1;
                n_state = S_CVW;
            end
            S_CVW: begin
                if (!w_cd_busy) begin
                    n_state = S_POSX;
                end
            end
            S_POSX: begin
                w_ma = 33'(r_vx);
                w_mb = $signed(33'(r_dt));
                n_state = S_POSY;
            end
            S_POSY: begin
                w_ma = 33'(r_vy);
                w_mb = $signed(33'(r_dt));
                n_state = S_POSS;
            end
            S_POSS: n_state = S_OUT;
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mu          <= 18'd52429;
            r_gas_accel   <= 23'd930611;
            r_brake_decel <= 23'd2555904;
            r_floor       <= 23'd262144;
            r_vref        <= 24'd2366577;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_FRICTION: r_mu          <= i_cfg.data[17:0];
                CFG_GAS:      r_gas_accel   <= i_cfg.data[22:0];
                CFG_BRAKE:    r_brake_decel <= i_cfg.data[22:0];
                CFG_FLOOR:    r_floor       <= i_cfg.data[22:0];
                CFG_VREF:     r_vref        <= i_cfg.data;
                default:      ;
            endcase
        end
    end

    // Car state updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= '0;
            r_py <= '0;
            r_vx <= '0;
            r_vy <= '0;
            r_hx <= HEAD_ONE;
            r_hy <= '0;
        end else begin
            case (r_state)
                S_VELY:  r_vx <= cpmd_sat32(68'(r_vx) + 68'(w_prod >>> 16));
                S_VELY2: r_vy <= cpmd_sat32(68'(r_vy) + 68'(w_prod >>> 16));
                S_DOTS: begin
                    if ((67'(r_dot) + 67'(w_prod)) < 0) begin
                        r_vx <= '0;
                        r_vy <= '0;
                    end
                end
                S_CHW: begin
                    if (!w_cd_busy) begin
                        r_hx <= cpmd_clamp_head(w_cd_ox);
                        r_hy <= cpmd_clamp_head(w_cd_oy);
                    end
                end
                S_CVW: begin
                    if (!w_cd_busy) begin
                        r_vx <= cpmd_sat32(68'(w_cd_ox));
                        r_vy <= cpmd_sat32(68'(w_cd_oy));
                    end
                end
                S_POSY: r_px <= cpmd_sat32(68'(r_px) + 68'(w_prod >>> 16));
                S_POSS: r_py <= cpmd_sat32(68'(r_py) + 68'(w_prod >>> 16));
                default: ;
            endcase
        end
    end

    // Intermediate values of the tick.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_gas   <= i_in.gas_pedal;
                    r_brake <= i_in.brake_pedal;
                    r_left  <= i_in.steer_left;
                    r_right <= i_in.steer_right;
                    r_dt    <= i_in.dt_step;
                end
            end
            S_SQY:   r_s <= w_prod[63:0];
            S_SQSUM: r_s <= r_s + w_prod[63:0];
            S_VREF2: r_vref2 <= w_prod[47:0];
            S_GMU:   r_gmu <= w_prod[36:16];
            S_RATIO: begin
                r_speed <= w_root;
                r_ratio <= (w_quo[79:47] != '0) ? {47{1'b1}} : w_quo[46:0];
            end
            S_GRIPB: r_t <= 64'(r_gmu) + w_prod[63:0];
            S_GRIPC: r_grip <= (w_grip_sum > 64'(GRIP_MAX)) ? GRIP_MAX : w_grip_sum[30:0];
            S_ACC: begin
                if (w_pedal) begin
                    r_acc <= (31'(w_sel) > r_grip) ? r_grip[22:0] : w_sel;
                end else begin
                    r_acc <= '0;
                end
            end
            S_STEP2: r_step <= r_brake ? -w_step_pos : w_step_pos;
            S_DOTY:  r_dot <= w_prod;
            S_LAT1:  r_t <= w_prod[63:0];
            S_RDIV:  r_rad <= (w_rq < 64'(w_floor)) ? 64'(w_floor) : w_rq;
            S_MOD1:  r_t <= w_rq - (w_prod[63:0] << 1);
            S_MOD2:  r_z <= r_right ? -w_zw : w_zw;
            S_CKHY:  r_cx <= w_prod[63:0];
            S_CKVY:  r_cx <= w_prod[63:0];
            default: ;
        endcase
    end

    // Result handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_px <= r_px;
            r_o_py <= r_py;
            r_o_vx <= r_vx;
            r_o_vy <= r_vy;
            r_o_hx <= r_hx;
            r_o_hy <= r_hy;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.pos_x  = r_o_px;
    assign o_out.pos_y  = r_o_py;
    assign o_out.vel_x  = r_o_vx;
    assign o_out.vel_y  = r_o_vy;
    assign o_out.head_x = r_o_hx;
    assign o_out.head_y = r_o_hy;
endmodule
`default_nettype wire

[hw/rtl/cpmd_checker.sv]
`default_nettype none
`include "assert_macros.svh"
// Port-level checks of the car block.
module cpmd_checker (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_in_valid,
    input wire               i_in_ready,
    input wire               i_out_valid,
    input wire               i_out_ready,
    input wire signed [17:0] i_head_x,
    input wire signed [17:0] i_head_y
);
    // A result beat stays offered until it is taken.
    `CPMD_ASSERT_RST(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> i_out_valid, "result beat dropped while stalled")

    // A stalled heading does not change.
    `CPMD_ASSERT_RST(a_out_stable, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> ($stable(i_head_x) && $stable(i_head_y)), "stalled payload changed")

    // Once a tick is taken the block works on it alone.
    `CPMD_ASSERT_RST(a_one_tick, i_clk, i_rst_n, (i_in_valid && i_in_ready) |=> !i_in_ready, "second tick accepted during work")

    // Heading components stay within the unit range.
    `CPMD_ASSERT_RST(a_head_range, i_clk, i_rst_n, i_out_valid |-> (i_head_x <= 18'sd65536 && i_head_x >= -18'sd65536 && i_head_y <= 18'sd65536 && i_head_y >= -18'sd65536), "heading out of range")

    // Reset leaves no result pending.
    `CPMD_ASSERT_ALL(a_reset_idle, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")
endmodule

bind car_point_mass_dynamics_step cpmd_checker u_cpmd_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_valid(i_in.valid),
    .i_in_ready(i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_head_x(o_out.head_x),
    .i_head_y(o_out.head_y)
);
`default_nettype wire
